/* design/etb_pkg.sv */
// Shared types and constants of the elimination tree builder.
package etb_pkg;

    localparam int unsigned IDX_W = 10;

    localparam logic ACT_ENTRY = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0] child;
        logic [IDX_W-1:0] parent;
    } t_result;

endpackage

/* design/etb_store.sv */
// Ancestor store: one write port, one read port with registered read data.
module etb_store #(
    parameter int unsigned AW = 10,
    parameter int unsigned DW = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/etb_walk.sv */
// Sequencer: clearing sweep, ancestor chain walk with path compression.
module etb_walk #(
    parameter int unsigned MAX_NODES = 1024,
    parameter int unsigned AW        = 10,
    parameter int unsigned DW        = 11
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_action,
    input  logic [etb_pkg::IDX_W-1:0]     i_row,
    input  logic [etb_pkg::IDX_W-1:0]     i_column,
    input  logic                          i_out_free,
    output logic                          o_res_valid,
    output etb_pkg::t_result              o_res,
    output logic                          o_mem_we,
    output logic [AW-1:0]                 o_mem_waddr,
    output logic [DW-1:0]                 o_mem_wdata,
    output logic                          o_mem_re,
    output logic [AW-1:0]                 o_mem_raddr,
    input  logic [DW-1:0]                 i_mem_rdata
);

    localparam logic [DW-1:0] NONE     = DW'(MAX_NODES);
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_NODES - 1);

    etb_pkg::t_state             r_state, n_state;
    logic [AW-1:0]               r_addr, n_addr;
    logic [etb_pkg::IDX_W-1:0]   r_node, n_node;
    logic [etb_pkg::IDX_W-1:0]   r_col, n_col;
    logic                        in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= etb_pkg::ST_CLEAR;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_col  <= n_col;
    end

    assign in_range = (32'(i_row) < 32'(MAX_NODES)) && (32'(i_column) < 32'(MAX_NODES));

    assign o_res.child  = r_node;
    assign o_res.parent = r_col;

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_node      = r_node;
        n_col       = r_col;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = '0;
        o_mem_re    = 1'b0;
        o_mem_raddr = '0;
        case (r_state)
            etb_pkg::ST_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_addr;
                o_mem_wdata = NONE;
                n_addr      = r_addr + 1'b1;
                if (r_addr == LAST_IDX) begin
                    n_addr  = '0;
                    n_state = etb_pkg::ST_IDLE;
                end
            end
            etb_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_action == etb_pkg::ACT_CLEAR) begin
                        n_addr  = '0;
                        n_state = etb_pkg::ST_CLEAR;
                    end else if (in_range && (i_row < i_column)) begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = AW'(i_row);
                        n_node      = i_row;
                        n_col       = i_column;
                        n_state     = etb_pkg::ST_WALK;
                    end
                end
            end
            etb_pkg::ST_WALK: begin
                // compress the visited node onto the column; the chain only
                // climbs, so the next read never hits the entry written here
                o_mem_we    = 1'b1;
                o_mem_waddr = AW'(r_node);
                o_mem_wdata = DW'(r_col);
                if (i_mem_rdata >= NONE) begin
                    if (i_out_free) begin
                        o_res_valid = 1'b1;
                        n_state     = etb_pkg::ST_IDLE;
                    end else begin
                        n_state = etb_pkg::ST_HOLD;
                    end
                end else if (32'(i_mem_rdata) < 32'(r_col)) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = AW'(i_mem_rdata);
                    n_node      = etb_pkg::IDX_W'(i_mem_rdata);
                end else begin
                    n_state = etb_pkg::ST_IDLE;
                end
            end
            etb_pkg::ST_HOLD: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    n_state     = etb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = etb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* design/elimination_tree_builder_core.sv */
// Elimination tree builder (Liu's algorithm with path compression).
// Input channel (i_in_valid/o_in_ready) carries entries: i_action selects a
// pattern entry or a clear of the ancestor store, i_row/i_column give the
// entry, columns non-decreasing. Output channel (o_out_valid/i_out_ready)
// carries (o_child, o_parent) pairs, at most one per entry.
// Entries with row not below column, or an index not below MAX_NODES,
// are dropped without a result.
// Each step of the chain walk is one read and one write-back on the
// ancestor store memory; no new entry is taken while a walk runs.
// Ignored entries leave the walker idle, ready for the next entry. Each
// result is registered in the output register.
// Reset and a clear action start a sweep that writes the none marker into
// every entry, during which o_in_ready is low.
// While the output register waits on i_out_ready the next entry is still
// taken and walked; its result is held until the register frees.
module elimination_tree_builder_core #(
    parameter int unsigned MAX_NODES = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_action,
    input  logic [etb_pkg::IDX_W-1:0] i_row,
    input  logic [etb_pkg::IDX_W-1:0] i_column,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [etb_pkg::IDX_W-1:0] o_child,
    output logic [etb_pkg::IDX_W-1:0] o_parent
);

    localparam int unsigned AW = $clog2(MAX_NODES);
    localparam int unsigned DW = $clog2(MAX_NODES + 1);

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [DW-1:0]        mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [DW-1:0]        mem_rdata;
    logic                 res_valid;
    etb_pkg::t_result     res;
    logic                 out_free;
    logic                 r_out_valid;
    etb_pkg::t_result     r_out;

    assign out_free = !r_out_valid || i_out_ready;

    etb_store #(
        .AW(AW),
        .DW(DW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    etb_walk #(
        .MAX_NODES(MAX_NODES),
        .AW       (AW),
        .DW       (DW)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_row       (i_row),
        .i_column    (i_column),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_child     = r_out.child;
    assign o_parent    = r_out.parent;

endmodule

/* design/etb_checker.sv */
// Port-level checks for the elimination tree builder, bound to the top level.
module etb_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input logic                      i_action,
    input logic [etb_pkg::IDX_W-1:0] i_row,
    input logic [etb_pkg::IDX_W-1:0] i_column,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic [etb_pkg::IDX_W-1:0] o_child,
    input logic [etb_pkg::IDX_W-1:0] o_parent
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_child) && $stable(o_parent))
        else $error("result changed while stalled");

    // a tree edge always points upward
    a_parent_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_parent > o_child)
        else $error("parent not above child");

    // the clearing sweep blocks input after reset
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input taken during clearing sweep");

    // a clear transfer starts the sweep
    a_clear_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_action == etb_pkg::ACT_CLEAR) |=> !o_in_ready)
        else $error("input taken right after clear");

    // the output register empties only on a transfer
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_out_valid) |-> $past(i_out_ready))
        else $error("result dropped");

endmodule

bind elimination_tree_builder_core etb_checker u_etb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_action    (i_action),
    .i_row       (i_row),
    .i_column    (i_column),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_child     (o_child),
    .o_parent    (o_parent)
);
